### rtl/msp_pkg.sv
// ----------------------------------------------------------------------------
// msp_pkg: shared types and constants for the motor speed PID drive
// Widths of the datapath, register indexes and the control word layout.
// ----------------------------------------------------------------------------
package msp_pkg;

	// field and datapath widths
	localparam int CNT_W   = 16;  // encoder count, setpoint
	localparam int SCL_W   = 16;  // speed scale
	localparam int GAIN_W  = 16;  // PID gains
	localparam int LIM_W   = 24;  // integral limit
	localparam int RPM_W   = 24;  // measured speed
	localparam int ERR_W   = 25;  // error, error sum, previous error
	localparam int SUM_W   = 26;  // error sum before clamp, derivative
	localparam int MOP_A_W = 17;  // multiplier operand a (scale or gain)
	localparam int MOP_B_W = 26;  // multiplier operand b
	localparam int PROD_W  = MOP_A_W + MOP_B_W;
	localparam int ACC_W   = PROD_W + 1;
	localparam int Q_SHIFT = 8;   // Q8.8 fraction bits
	localparam int CORR_W  = ACC_W - Q_SHIFT;
	localparam int DACC_W  = 32;  // drive accumulator
	localparam int NACC_W  = CORR_W + 1;
	localparam int LVL_W   = 8;
	localparam int DRV_W   = LVL_W + 1;
	localparam int DRIVE_MAX = 255;

	// configuration port
	localparam int CFG_IW = 3;
	localparam int CFG_DW = 24;
	localparam logic [CFG_IW-1:0] REG_SPEED_SCALE = 3'd0;
	localparam logic [CFG_IW-1:0] REG_GAIN_PROP   = 3'd1;
	localparam logic [CFG_IW-1:0] REG_GAIN_INTEG  = 3'd2;
	localparam logic [CFG_IW-1:0] REG_GAIN_DERIV  = 3'd3;
	localparam logic [CFG_IW-1:0] REG_INTEG_LIMIT = 3'd4;
	localparam logic [SCL_W-1:0]  SPEED_SCALE_RST = 16'd256;

	// microprogram
	localparam int STEP_W = 3;

	typedef enum logic [1:0] {
		MSRC_SPEED = 2'd0,
		MSRC_PROP  = 2'd1,
		MSRC_INTEG = 2'd2,
		MSRC_DERIV = 2'd3
	} msp_msrc_t;

	typedef enum logic [1:0] {
		AOP_HOLD = 2'd0,
		AOP_LOAD = 2'd1,
		AOP_ADD  = 2'd2
	} msp_aop_t;

	typedef enum logic [1:0] {
		JC_NONE     = 2'd0,
		JC_WAIT_IN  = 2'd1,
		JC_WAIT_OUT = 2'd2
	} msp_jc_t;

	// one control word of the microprogram
	typedef struct packed {
		logic              take_in;  // step may accept an input beat
		msp_msrc_t         msrc;     // multiplier operand pair
		msp_aop_t          aop;      // product accumulator operation
		logic              err_en;   // form speed and error
		logic              upd_en;   // update error sum, derivative, prev error
		logic              fin;      // update drive accumulator, load result
		msp_jc_t           jc;       // jump condition
		logic [STEP_W-1:0] jtgt;     // jump target
	} msp_uword_t;

	// datapath status back to the sequencer
	typedef struct packed {
		logic out_busy;  // result register full and not being drained
	} msp_stat_t;

endpackage

### rtl/msp_seq.sv
// ----------------------------------------------------------------------------
// msp_seq: microprogram sequencer
// Step counter, control store and conditional jumps.
// ----------------------------------------------------------------------------
module msp_seq
	import msp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  msp_stat_t  stat,
	output msp_uword_t ctrl
);

	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] step_d;
	logic              jump;

	// control store
	always_comb begin
		ctrl = '0;
		unique case (step_q)
			3'd0: begin  // wait for a sample
				ctrl.take_in = 1'b1;
				ctrl.jc      = JC_WAIT_IN;
				ctrl.jtgt    = 3'd0;
			end
			3'd1: begin  // count * scale
				ctrl.msrc = MSRC_SPEED;
			end
			3'd2: begin  // speed, error
				ctrl.err_en = 1'b1;
			end
			3'd3: begin  // integral, derivative; gp * err
				ctrl.upd_en = 1'b1;
				ctrl.msrc   = MSRC_PROP;
			end
			3'd4: begin  // gi * sum
				ctrl.msrc = MSRC_INTEG;
				ctrl.aop  = AOP_LOAD;
			end
			3'd5: begin  // gd * deriv
				ctrl.msrc = MSRC_DERIV;
				ctrl.aop  = AOP_ADD;
			end
			3'd6: begin
				ctrl.aop = AOP_ADD;
			end
			3'd7: begin  // accumulate drive, hold until result slot frees
				ctrl.fin  = 1'b1;
				ctrl.jc   = JC_WAIT_OUT;
				ctrl.jtgt = 3'd7;
			end
			default: ctrl = '0;
		endcase
	end

	// jump evaluation
	always_comb begin
		unique case (ctrl.jc)
			JC_WAIT_IN:  jump = !in_valid;
			JC_WAIT_OUT: jump = stat.out_busy;
			default:     jump = 1'b0;
		endcase
		step_d = jump ? ctrl.jtgt : step_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else begin
			step_q <= step_d;
		end
	end

endmodule

### rtl/msp_dp.sv
// ----------------------------------------------------------------------------
// msp_dp: PID datapath
// One shared signed multiplier, product accumulator, controller state and
// the result register.
// ----------------------------------------------------------------------------
module msp_dp
	import msp_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  msp_uword_t               ctrl,
	output msp_stat_t                stat,
	input  logic                     in_valid,
	input  logic signed [CNT_W-1:0]  enc_count,
	input  logic signed [CNT_W-1:0]  target_rpm,
	input  logic [SCL_W-1:0]         speed_scale,
	input  logic signed [GAIN_W-1:0] gain_prop,
	input  logic signed [GAIN_W-1:0] gain_integ,
	input  logic signed [GAIN_W-1:0] gain_deriv,
	input  logic [LIM_W-1:0]         integ_limit,
	input  logic                     out_ready,
	output logic                     out_valid,
	output logic [LVL_W-1:0]         drive_level,
	output logic                     dir_fwd,
	output logic                     dir_rev,
	output logic signed [RPM_W-1:0]  measured_rpm
);

	logic signed [CNT_W-1:0]   cnt_q, tgt_q;
	logic signed [MOP_A_W-1:0] mop_a;
	logic signed [MOP_B_W-1:0] mop_b;
	logic signed [PROD_W-1:0]  prod_d, prod_q;
	logic signed [ACC_W-1:0]   prod_x, acc_q;
	logic signed [RPM_W-1:0]   speed, speed_q;
	logic signed [ERR_W-1:0]   err_d, err_q, prev_q, esum_q;
	logic signed [SUM_W-1:0]   sum_raw, lim_pos, lim_neg, esum_d, deriv_q;
	logic signed [CORR_W-1:0]  corr;
	logic signed [NACC_W-1:0]  nacc;
	logic signed [DACC_W-1:0]  dacc_d, dacc_q;
	logic signed [DRV_W-1:0]   drv;
	logic                      out_valid_q;
	logic                      fire;

	assign stat.out_busy = out_valid_q && !out_ready;
	assign fire          = ctrl.fin && !stat.out_busy;

	// sample capture
	always_ff @(posedge clk) begin
		if (ctrl.take_in && in_valid) begin
			cnt_q <= enc_count;
			tgt_q <= target_rpm;
		end
	end

	// multiplier operand select
	always_comb begin
		case (ctrl.msrc)
			MSRC_PROP: begin
				mop_a = {gain_prop[GAIN_W-1], gain_prop};
				mop_b = {err_q[ERR_W-1], err_q};
			end
			MSRC_INTEG: begin
				mop_a = {gain_integ[GAIN_W-1], gain_integ};
				mop_b = {esum_q[ERR_W-1], esum_q};
			end
			MSRC_DERIV: begin
				mop_a = {gain_deriv[GAIN_W-1], gain_deriv};
				mop_b = deriv_q;
			end
			default: begin
				mop_a = {1'b0, speed_scale};
				mop_b = {{(MOP_B_W-CNT_W){cnt_q[CNT_W-1]}}, cnt_q};
			end
		endcase
	end

	assign prod_d = mop_a * mop_b;
	assign prod_x = {prod_q[PROD_W-1], prod_q};

	always_ff @(posedge clk) begin
		prod_q <= prod_d;
		case (ctrl.aop)
			AOP_LOAD: acc_q <= prod_x;
			AOP_ADD:  acc_q <= acc_q + prod_x;
			default:  acc_q <= acc_q;
		endcase
	end

	// speed is floor(count * scale / 256); error is setpoint minus speed
	assign speed = $signed(prod_q[Q_SHIFT+RPM_W-1:Q_SHIFT]);
	assign err_d = {tgt_q[CNT_W-1], {(ERR_W-CNT_W-1){tgt_q[CNT_W-1]}}, tgt_q}
		- {speed[RPM_W-1], speed};

	always_ff @(posedge clk) begin
		if (ctrl.err_en) begin
			speed_q <= speed;
			err_q   <= err_d;
		end
	end

	// clamped integral
	assign sum_raw = {esum_q[ERR_W-1], esum_q} + {err_q[ERR_W-1], err_q};
	assign lim_pos = {{(SUM_W-LIM_W){1'b0}}, integ_limit};
	assign lim_neg = -lim_pos;

	always_comb begin
		if (sum_raw > lim_pos) begin
			esum_d = lim_pos;
		end else if (sum_raw < lim_neg) begin
			esum_d = lim_neg;
		end else begin
			esum_d = sum_raw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esum_q <= '0;
			prev_q <= '0;
		end else if (ctrl.upd_en) begin
			esum_q <= esum_d[ERR_W-1:0];
			prev_q <= err_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.upd_en) begin
			deriv_q <= {err_q[ERR_W-1], err_q} - {prev_q[ERR_W-1], prev_q};
		end
	end

	// velocity-form accumulator, saturating at 32 bits
	assign corr = acc_q[ACC_W-1:Q_SHIFT];
	assign nacc = {{(NACC_W-DACC_W){dacc_q[DACC_W-1]}}, dacc_q} + {corr[CORR_W-1], corr};

	always_comb begin
		if (nacc[NACC_W-1:DACC_W-1] != {(NACC_W-DACC_W+1){nacc[NACC_W-1]}}) begin
			dacc_d = nacc[NACC_W-1] ? {1'b1, {(DACC_W-1){1'b0}}} : {1'b0, {(DACC_W-1){1'b1}}};
		end else begin
			dacc_d = nacc[DACC_W-1:0];
		end
		if (dacc_d > DACC_W'(DRIVE_MAX)) begin
			drv = DRV_W'(DRIVE_MAX);
		end else if (dacc_d < -DACC_W'(DRIVE_MAX)) begin
			drv = -DRV_W'(DRIVE_MAX);
		end else begin
			drv = dacc_d[DRV_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dacc_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				dacc_q <= dacc_d;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (fire) begin
			drive_level  <= drv[DRV_W-1] ? LVL_W'(-drv) : drv[LVL_W-1:0];
			dir_fwd      <= !drv[DRV_W-1] && (drv != '0);
			dir_rev      <= drv[DRV_W-1];
			measured_rpm <= speed_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

### rtl/motor_speed_pid_drive.sv
// ----------------------------------------------------------------------------
// motor_speed_pid_drive: velocity-form PID motor speed controller
// Configuration registers and the microcoded PID engine.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one sample per beat: the signed
//   encoder count of the sample period and the target speed in rpm.
//   Output channel (out_valid/out_ready) returns one beat per sample: drive
//   magnitude 0..255, forward/reverse bits (both low at zero drive) and the
//   measured speed in rpm.
//   Registers are written through cfg_we/cfg_idx/cfg_wdata; the user must
//   write them only while idle, which the block itself does not enforce:
//   0 speed_scale, 1 gain_prop, 2 gain_integ, 3 gain_deriv, 4 integ_limit.
//   Writes to other indexes are dropped.
//   The engine takes no new sample until the last one is loaded into the
//   output register: the eight-step microprogram runs all four multiplies
//   through one shared 17x26 multiplier.
//   Reset clears the integral, previous error, drive accumulator and output
//   valid, and loads the register defaults (scale 1.0, gains 0, limit max).
//   When the receiver stalls, one finished result waits in the output
//   register while the next sample is accepted and computed; the engine
//   then holds in its last step until the output register frees.
// ----------------------------------------------------------------------------
module motor_speed_pid_drive
	import msp_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IW-1:0]       cfg_idx,
	input  logic [CFG_DW-1:0]       cfg_wdata,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [CNT_W-1:0] enc_count,
	input  logic signed [CNT_W-1:0] target_rpm,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [LVL_W-1:0]        drive_level,
	output logic                    dir_fwd,
	output logic                    dir_rev,
	output logic signed [RPM_W-1:0] measured_rpm
);

	logic [SCL_W-1:0]         speed_scale_q;
	logic signed [GAIN_W-1:0] gain_prop_q, gain_integ_q, gain_deriv_q;
	logic [LIM_W-1:0]         integ_limit_q;
	msp_uword_t               ctrl;
	msp_stat_t                stat;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_scale_q <= SPEED_SCALE_RST;
			gain_prop_q   <= '0;
			gain_integ_q  <= '0;
			gain_deriv_q  <= '0;
			integ_limit_q <= '1;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_SPEED_SCALE: speed_scale_q <= cfg_wdata[SCL_W-1:0];
				REG_GAIN_PROP:   gain_prop_q   <= $signed(cfg_wdata[GAIN_W-1:0]);
				REG_GAIN_INTEG:  gain_integ_q  <= $signed(cfg_wdata[GAIN_W-1:0]);
				REG_GAIN_DERIV:  gain_deriv_q  <= $signed(cfg_wdata[GAIN_W-1:0]);
				REG_INTEG_LIMIT: integ_limit_q <= cfg_wdata[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_ready = ctrl.take_in;

	msp_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	msp_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.stat         (stat),
		.in_valid     (in_valid),
		.enc_count    (enc_count),
		.target_rpm   (target_rpm),
		.speed_scale  (speed_scale_q),
		.gain_prop    (gain_prop_q),
		.gain_integ   (gain_integ_q),
		.gain_deriv   (gain_deriv_q),
		.integ_limit  (integ_limit_q),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.drive_level  (drive_level),
		.dir_fwd      (dir_fwd),
		.dir_rev      (dir_rev),
		.measured_rpm (measured_rpm)
	);

endmodule

### tb/motor_speed_pid_drive_test.sv
// ----------------------------------------------------------------------------
// motor_speed_pid_drive_test: self-checking bench for the PID motor drive
// Streams encoder/setpoint samples through the valid/ready input channel and
// checks every output beat against a cycle-free PID predictor kept in the
// bench. Runs several register settings and idling mixes, including a long
// receiver hold-off that backs the engine up into its input.
// ----------------------------------------------------------------------------
module motor_speed_pid_drive_test
	import msp_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int HOLD_LEN    = 200;   // receiver hold-off, cycles
	localparam int QUIET_LIMIT = 4000;  // cycles with no beat before giving up
	localparam int MAX_SHOWN   = 10;
	localparam int N_PHASES    = 8;
	localparam int PHASE_ITEMS = 167;

	localparam logic [CNT_W-1:0]  CNT_MIN = 16'h8000;
	localparam logic [CNT_W-1:0]  CNT_MAX = 16'h7FFF;
	localparam logic [GAIN_W-1:0] GAIN_MIN = 16'h8000;
	localparam logic [GAIN_W-1:0] GAIN_MAX = 16'h7FFF;
	localparam logic [SCL_W-1:0]  SCALE_MAX = 16'hFFFF;
	localparam logic [LIM_W-1:0]  LIMIT_MAX = 24'hFFFFFF;
	localparam logic [CFG_IW-1:0] REG_UNUSED = REG_INTEG_LIMIT + 3'd1;
	localparam longint ACC_HI = 64'sd2147483647;
	localparam longint ACC_LO = -ACC_HI - 64'sd1;

	typedef struct {
		logic [CNT_W-1:0] cnt;
		logic [CNT_W-1:0] tgt;
	} sample_t;

	typedef struct {
		logic [LVL_W-1:0]        level;
		logic                    fwd;
		logic                    rev;
		logic signed [RPM_W-1:0] rpm;
	} drive_result_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_we = 1'b0;
	logic [CFG_IW-1:0]       cfg_idx = '0;
	logic [CFG_DW-1:0]       cfg_wdata = '0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic signed [CNT_W-1:0] enc_count = '0;
	logic signed [CNT_W-1:0] target_rpm = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [LVL_W-1:0]        drive_level;
	logic                    dir_fwd;
	logic                    dir_rev;
	logic signed [RPM_W-1:0] measured_rpm;

	motor_speed_pid_drive DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.enc_count(enc_count),
		.target_rpm(target_rpm),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.drive_level(drive_level),
		.dir_fwd(dir_fwd),
		.dir_rev(dir_rev),
		.measured_rpm(measured_rpm)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// shadow registers and controller state
	logic [SCL_W-1:0]         cfg_scale = SPEED_SCALE_RST;
	logic signed [GAIN_W-1:0] cfg_kp = '0;
	logic signed [GAIN_W-1:0] cfg_ki = '0;
	logic signed [GAIN_W-1:0] cfg_kd = '0;
	logic [LIM_W-1:0]         cfg_limit = LIMIT_MAX;
	logic signed [ERR_W-1:0]  last_err = '0;
	logic signed [ERR_W-1:0]  err_acc = '0;
	logic signed [DACC_W-1:0] duty_acc = '0;

	sample_t       sample_q[$];
	drive_result_t drive_exp_q[$];

	int  tx_idle_pct = 0;
	int  rx_stall_pct = 0;
	bit  hold_req = 1'b0;
	int  hold_cnt = 0;
	logic in_beat = 1'b0;
	int  quiet_cycles = 0;
	int  n_in = 0, n_out = 0, n_err = 0, n_configs = 0;
	int  n_fwd = 0, n_rev = 0, n_zero = 0, n_sat = 0;

	// one sample through the velocity-form PID; updates the shadow state
	function automatic drive_result_t predict_drive(input logic signed [CNT_W-1:0] cnt,
			input logic signed [CNT_W-1:0] tgt);
		longint speed, err, sum, deriv, corr, acc, drv, lim;
		drive_result_t r;
		speed = (longint'(cnt) * longint'(cfg_scale)) >>> Q_SHIFT;
		err   = longint'(tgt) - speed;
		lim   = longint'(cfg_limit);
		sum   = longint'(err_acc) + err;
		if (sum > lim)
			sum = lim;
		if (sum < -lim)
			sum = -lim;
		err_acc  = ERR_W'(sum);
		deriv    = err - longint'(last_err);
		last_err = ERR_W'(err);
		corr = (longint'(cfg_kp) * err + longint'(cfg_ki) * sum
			+ longint'(cfg_kd) * deriv) >>> Q_SHIFT;
		acc = longint'(duty_acc) + corr;
		if (acc > ACC_HI)
			acc = ACC_HI;
		if (acc < ACC_LO)
			acc = ACC_LO;
		duty_acc = DACC_W'(acc);
		if (acc == ACC_HI || acc == ACC_LO)
			n_sat++;
		drv = acc;
		if (drv > DRIVE_MAX)
			drv = DRIVE_MAX;
		if (drv < -DRIVE_MAX)
			drv = -DRIVE_MAX;
		r.level = LVL_W'(drv < 0 ? -drv : drv);
		r.fwd   = (drv > 0);
		r.rev   = (drv < 0);
		r.rpm   = RPM_W'(speed);
		return r;
	endfunction

	// register write; the shadow copy follows the same index decode
	task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_SPEED_SCALE: cfg_scale = val[SCL_W-1:0];
			REG_GAIN_PROP:   cfg_kp = val[GAIN_W-1:0];
			REG_GAIN_INTEG:  cfg_ki = val[GAIN_W-1:0];
			REG_GAIN_DERIV:  cfg_kd = val[GAIN_W-1:0];
			REG_INTEG_LIMIT: cfg_limit = val[LIM_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [SCL_W-1:0] scale, input logic [GAIN_W-1:0] kp,
			input logic [GAIN_W-1:0] ki, input logic [GAIN_W-1:0] kd,
			input logic [LIM_W-1:0] lim);
		write_reg(REG_SPEED_SCALE, CFG_DW'(scale));
		write_reg(REG_GAIN_PROP, CFG_DW'(kp));
		write_reg(REG_GAIN_INTEG, CFG_DW'(ki));
		write_reg(REG_GAIN_DERIV, CFG_DW'(kd));
		write_reg(REG_INTEG_LIMIT, lim);
		// index past the register file, must be dropped
		write_reg(REG_UNUSED + CFG_IW'($urandom_range(0, 2)), CFG_DW'($urandom));
		@(negedge clk);
		cfg_we <= 1'b0;
		n_configs++;
	endtask

	task automatic push_sample(input logic [CNT_W-1:0] cnt, input logic [CNT_W-1:0] tgt);
		sample_t s;
		s.cnt = cnt;
		s.tgt = tgt;
		sample_q.push_back(s);
	endtask

	task automatic wait_drained();
		while (sample_q.size() != 0 || in_valid || drive_exp_q.size() != 0)
			@(negedge clk);
	endtask

	// sender: next sample only once the current beat is gone
	always @(negedge clk) begin
		logic    nv;
		sample_t s;
		nv = in_valid && !in_beat;
		if (!nv && arst_n && sample_q.size() != 0
				&& $urandom_range(0, 99) >= tx_idle_pct) begin
			s = sample_q.pop_front();
			enc_count  <= s.cnt;
			target_rpm <= s.tgt;
			nv = 1'b1;
		end
		in_valid <= nv;
	end

	// receiver: random stalls plus one long hold-off on request
	always @(negedge clk) begin
		logic rdy;
		rdy = ($urandom_range(0, 99) >= rx_stall_pct);
		if (hold_req && hold_cnt < HOLD_LEN) begin
			rdy = 1'b0;
			hold_cnt++;
		end
		out_ready <= rdy;
	end

	// beat capture, prediction, checking and watchdog
	always @(posedge clk) begin
		drive_result_t e;
		in_beat <= in_valid && in_ready;
		if (in_valid && in_ready) begin
			drive_exp_q.push_back(predict_drive(enc_count, target_rpm));
			n_in++;
		end
		if (out_valid && out_ready) begin
			n_out++;
			if (dir_fwd)
				n_fwd++;
			else if (dir_rev)
				n_rev++;
			else
				n_zero++;
			if (drive_exp_q.size() == 0) begin
				n_err++;
				if (n_err <= MAX_SHOWN)
					$display("ERROR: result beat %0d with nothing expected", n_out);
			end else begin
				e = drive_exp_q.pop_front();
				if (drive_level !== e.level || dir_fwd !== e.fwd || dir_rev !== e.rev
						|| measured_rpm !== e.rpm) begin
					n_err++;
					if (n_err <= MAX_SHOWN)
						$display({"ERROR: beat %0d exp lvl=%0d fwd=%b rev=%b rpm=%0d,",
							" got lvl=%0d fwd=%b rev=%b rpm=%0d"},
							n_out, e.level, e.fwd, e.rev, e.rpm,
							drive_level, dir_fwd, dir_rev, measured_rpm);
				end
			end
		end
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("ERROR: no beat for %0d cycles, %0d in, %0d out",
				QUIET_LIMIT, n_in, n_out);
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		int               p, i;
		logic [SCL_W-1:0] scale;
		logic [GAIN_W-1:0] kp, ki, kd;
		logic [LIM_W-1:0] lim;
		logic [CNT_W-1:0] tgt, cnt;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: gains zero, so drive stays at zero with both dirs low
		push_sample(CNT_MIN, CNT_MAX);
		push_sample(CNT_MAX, CNT_MIN);
		push_sample('0, '0);
		push_sample(16'hFFFF, 16'h0001);
		wait_drained();

		// widest scale, unity P only, zero integral limit
		set_config(SCALE_MAX, 16'h0100, '0, '0, '0);
		push_sample(CNT_MIN, CNT_MAX);
		push_sample(CNT_MAX, CNT_MIN);
		push_sample(16'h0001, '0);
		push_sample('0, '0);
		push_sample('0, '0);
		wait_drained();

		// max gains on the largest errors: accumulator runs into both rails
		set_config(SCALE_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, LIMIT_MAX);
		repeat (4) push_sample(CNT_MIN, CNT_MAX);
		repeat (4) push_sample(CNT_MAX, CNT_MIN);
		wait_drained();

		// zero scale, most negative gains, tiny integral limit
		set_config('0, GAIN_MIN, GAIN_MIN, GAIN_MIN, 24'd1);
		push_sample(CNT_MAX, CNT_MIN);
		push_sample(CNT_MIN, CNT_MAX);
		wait_drained();

		// random phases
		for (p = 0; p < N_PHASES; p++) begin
			scale = SPEED_SCALE_RST;
			kp    = GAIN_W'($urandom_range(0, 1200) - 600);
			ki    = GAIN_W'($urandom_range(0, 200) - 100);
			kd    = GAIN_W'($urandom_range(0, 600) - 300);
			lim   = LIM_W'($urandom_range(0, 50000));
			case (p)
				1, 5: begin
					scale = SCL_W'($urandom);
					kp    = GAIN_W'($urandom);
					ki    = GAIN_W'($urandom);
					kd    = GAIN_W'($urandom);
					lim   = LIM_W'($urandom);
				end
				2: begin
					scale = SCL_W'($urandom_range(0, 2048));
					lim   = '0;
				end
				3: begin
					scale = SCALE_MAX;
					kp    = GAIN_MIN;
					ki    = GAIN_MIN;
					kd    = GAIN_MIN;
					lim   = LIMIT_MAX;
				end
				4: scale = SCL_W'($urandom_range(0, 1024));
				6: begin
					scale = '0;
					kp    = GAIN_MAX;
					ki    = GAIN_MAX;
					kd    = GAIN_MAX;
				end
				default: ;
			endcase
			set_config(scale, kp, ki, kd, lim);
			tx_idle_pct  = (p % 4 == 1) ? 52 : (p % 4 == 3) ? 10 : 0;
			rx_stall_pct = (p % 4 == 2) ? 52 : (p % 4 == 3) ? 10 : 0;

			// setpoint held for runs of samples, counts jitter around small values
			tgt = GAIN_W'($urandom_range(0, 6000) - 3000);
			for (i = 0; i < PHASE_ITEMS; i++) begin
				if ($urandom_range(0, 15) == 0)
					tgt = ($urandom_range(0, 3) == 0) ? CNT_W'($urandom)
						: CNT_W'($urandom_range(0, 6000) - 3000);
				case ($urandom_range(0, 15))
					0:       cnt = ($urandom_range(0, 1) != 0) ? CNT_MAX : CNT_MIN;
					1, 2:    cnt = CNT_W'($urandom);
					default: cnt = CNT_W'($urandom_range(0, 200) - 100);
				endcase
				push_sample(cnt, tgt);
			end
			// back the engine up into its input while samples keep coming
			if (p == 4)
				hold_req = 1'b1;
			wait_drained();
		end

		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		repeat (4 * 8) @(negedge clk);

		$display("Ran %0d samples over %0d register settings, %0d results checked",
			n_in, n_configs, n_out);
		$display("Drive forward %0d, reverse %0d, zero %0d; accumulator at a rail %0d times",
			n_fwd, n_rev, n_zero, n_sat);
		if (drive_exp_q.size() != 0) begin
			n_err++;
			$display("ERROR: %0d expected results never arrived", drive_exp_q.size());
		end
		if (n_err == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("%0d mismatches in total", n_err);
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/msp_pkg.sv
rtl/msp_seq.sv
rtl/msp_dp.sv
rtl/motor_speed_pid_drive.sv
tb/motor_speed_pid_drive_test.sv
